FILE: rtl/mrps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrps_pkg: shared types and constants for the masked ROI pixel statistics
// Widths of the accumulators, the shared add/subtract unit and its request
// and response groups, the sequencer states and the statistics bundle.
// ----------------------------------------------------------------------------
package mrps_pkg;

    localparam int unsigned PIX_W     = 16;
    localparam int unsigned COUNT_W   = 21;
    localparam int unsigned SUM_W     = 36;
    localparam int unsigned SQSUM_W   = 52;
    localparam int unsigned PROD_W    = 72;
    localparam int unsigned ALU_W     = 88;
    localparam int unsigned ROOT_W    = 44;
    localparam int unsigned REM_W     = 48;
    localparam int unsigned DIVREM_W  = COUNT_W + 1;
    localparam int unsigned MEAN_W    = 24;
    localparam int unsigned SD_W      = 23;
    localparam int unsigned STEP_W    = 6;

    localparam int unsigned MUL_A_STEPS = COUNT_W;
    localparam int unsigned MUL_B_STEPS = SUM_W;
    localparam int unsigned ROOT_STEPS  = ROOT_W;
    localparam int unsigned DIV_STEPS   = ROOT_W;

    typedef logic [PIX_W-1:0]    t_pix;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [SQSUM_W-1:0]  t_sqsum;
    typedef logic [PROD_W-1:0]   t_prod;
    typedef logic [ALU_W-1:0]    t_alu_word;
    typedef logic [ROOT_W-1:0]   t_root;
    typedef logic [REM_W-1:0]    t_rem;
    typedef logic [DIVREM_W-1:0] t_divrem;
    typedef logic [STEP_W-1:0]   t_step;

    localparam t_count MAX_ROI_PIXELS = t_count'(1048576);
    localparam t_pix   EMPTY_MIN      = '1;

    typedef struct packed {
        t_count count;
        t_sum   sum;
        t_sqsum sqsum;
        t_pix   min;
        t_pix   max;
    } t_acc_stats;

    typedef struct packed {
        logic      sub;
        t_alu_word op_a;
        t_alu_word op_b;
    } t_alu_req;

    typedef struct packed {
        logic      no_borrow;
        t_alu_word sum;
    } t_alu_rsp;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOAD  = 9'b000000010,
        S_MULA  = 9'b000000100,
        S_MULB  = 9'b000001000,
        S_SUB   = 9'b000010000,
        S_SQRT  = 9'b000100000,
        S_DSD   = 9'b001000000,
        S_DMEAN = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/mrps_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrps_alu: shared add/subtract unit
// One wide adder; subtract adds the inverted operand plus one, and the carry
// out flags op_a >= op_b.
// ----------------------------------------------------------------------------
module mrps_alu (
    input  wire  mrps_pkg::t_alu_req i_req,
    output mrps_pkg::t_alu_rsp       o_rsp
);

    logic [mrps_pkg::ALU_W:0] w_total;
    mrps_pkg::t_alu_word      w_op_b;

    assign w_op_b  = i_req.sub ? ~i_req.op_b : i_req.op_b;
    assign w_total = {1'b0, i_req.op_a} + {1'b0, w_op_b}
                   + {{mrps_pkg::ALU_W{1'b0}}, i_req.sub};

    assign o_rsp.sum       = w_total[mrps_pkg::ALU_W-1:0];
    assign o_rsp.no_borrow = w_total[mrps_pkg::ALU_W];

endmodule
`default_nettype wire

FILE: rtl/mrps_acc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrps_acc: per-pixel accumulators
// Count, sum, sum of squares, minimum and maximum over masked-in pixels, one
// pixel per cycle while i_upd is high; cleared when a result is handed off.
// ----------------------------------------------------------------------------
module mrps_acc (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_upd,
    input  wire  mrps_pkg::t_pix i_pix,
    input  wire                 i_roi,
    input  wire                 i_clear,
    output mrps_pkg::t_acc_stats o_stats
);

    mrps_pkg::t_count r_count, n_count;
    mrps_pkg::t_sum   r_sum,   n_sum;
    mrps_pkg::t_sqsum r_sqsum, n_sqsum;
    mrps_pkg::t_pix   r_min,   n_min;
    mrps_pkg::t_pix   r_max,   n_max;
    logic [2*mrps_pkg::PIX_W-1:0] w_square;
    logic                         w_take;

    assign w_square = i_pix * i_pix;
    assign w_take   = i_upd && i_roi && (r_count < mrps_pkg::MAX_ROI_PIXELS);

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_sqsum = r_sqsum;
        n_min   = r_min;
        n_max   = r_max;
        if (i_clear) begin
            n_count = '0;
            n_sum   = '0;
            n_sqsum = '0;
            n_min   = mrps_pkg::EMPTY_MIN;
            n_max   = '0;
        end else if (w_take) begin
            n_count = r_count + 1'b1;
            n_sum   = r_sum + mrps_pkg::t_sum'(i_pix);
            n_sqsum = r_sqsum + mrps_pkg::t_sqsum'(w_square);
            if (i_pix < r_min) begin
                n_min = i_pix;
            end
            if (i_pix > r_max) begin
                n_max = i_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sqsum <= '0;
            r_min   <= mrps_pkg::EMPTY_MIN;
            r_max   <= '0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_sqsum <= n_sqsum;
            r_min   <= n_min;
            r_max   <= n_max;
        end
    end

    assign o_stats.count = r_count;
    assign o_stats.sum   = r_sum;
    assign o_stats.sqsum = r_sqsum;
    assign o_stats.min   = r_min;
    assign o_stats.max   = r_max;

endmodule
`default_nettype wire

FILE: rtl/mrps_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrps_seq: result sequencer
// Drives the shared add/subtract unit through shift-add products, a
// restoring square root and two restoring divisions, one bit per cycle.
// ----------------------------------------------------------------------------
module mrps_seq (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire  mrps_pkg::t_acc_stats i_stats,
    input  wire                      i_out_free,
    output logic                     o_idle,
    output logic                     o_done,
    output logic [mrps_pkg::MEAN_W-1:0] o_mean,
    output logic [mrps_pkg::SD_W-1:0]   o_sd
);

    mrps_pkg::t_state    r_state, n_state;
    mrps_pkg::t_step     r_cnt,   n_cnt;
    mrps_pkg::t_alu_word r_x,     n_x;
    mrps_pkg::t_prod     r_y,     n_y;
    mrps_pkg::t_alu_word r_m,     n_m;
    mrps_pkg::t_sum      r_q,     n_q;
    mrps_pkg::t_rem      r_rem,   n_rem;
    mrps_pkg::t_root     r_root,  n_root;
    logic [mrps_pkg::SD_W-1:0]   r_sd,   n_sd;
    logic [mrps_pkg::MEAN_W-1:0] r_mean, n_mean;

    mrps_pkg::t_alu_req w_req;
    mrps_pkg::t_alu_rsp w_rsp;
    mrps_pkg::t_rem     w_sq_sh;
    mrps_pkg::t_divrem  w_div_sh;
    mrps_pkg::t_alu_word w_mul_b;
    mrps_pkg::t_root    w_quot;
    mrps_pkg::t_root    w_mean_dvd;

    mrps_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign w_sq_sh    = {r_rem[mrps_pkg::REM_W-3:0], r_x[mrps_pkg::ALU_W-1 -: 2]};
    assign w_div_sh   = {r_rem[mrps_pkg::COUNT_W-1:0], r_root[mrps_pkg::ROOT_W-1]};
    assign w_mul_b    = r_q[0] ? r_m : '0;
    assign w_quot     = {r_root[mrps_pkg::ROOT_W-2:0], w_rsp.no_borrow};
    assign w_mean_dvd = {i_stats.sum, 8'h00};

    always_comb begin
        w_req = '0;
        unique case (r_state)
            mrps_pkg::S_MULA: begin
                w_req.op_a = r_x;
                w_req.op_b = w_mul_b;
            end
            mrps_pkg::S_MULB: begin
                w_req.op_a = mrps_pkg::t_alu_word'(r_y);
                w_req.op_b = w_mul_b;
            end
            mrps_pkg::S_SUB: begin
                w_req.sub  = 1'b1;
                w_req.op_a = r_x;
                w_req.op_b = mrps_pkg::t_alu_word'(r_y);
            end
            mrps_pkg::S_SQRT: begin
                w_req.sub  = 1'b1;
                w_req.op_a = mrps_pkg::t_alu_word'(w_sq_sh);
                w_req.op_b = mrps_pkg::t_alu_word'({r_root, 2'b01});
            end
            mrps_pkg::S_DSD, mrps_pkg::S_DMEAN: begin
                w_req.sub  = 1'b1;
                w_req.op_a = mrps_pkg::t_alu_word'(w_div_sh);
                w_req.op_b = mrps_pkg::t_alu_word'(i_stats.count);
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_x     = r_x;
        n_y     = r_y;
        n_m     = r_m;
        n_q     = r_q;
        n_rem   = r_rem;
        n_root  = r_root;
        n_sd    = r_sd;
        n_mean  = r_mean;
        unique case (r_state)
            mrps_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = mrps_pkg::S_LOAD;
                end
            end
            mrps_pkg::S_LOAD: begin
                if (i_stats.count == '0) begin
                    n_sd    = '0;
                    n_mean  = '0;
                    n_state = mrps_pkg::S_DONE;
                end else begin
                    n_x     = '0;
                    n_m     = mrps_pkg::t_alu_word'(i_stats.sqsum);
                    n_q     = mrps_pkg::t_sum'(i_stats.count);
                    n_cnt   = mrps_pkg::t_step'(mrps_pkg::MUL_A_STEPS - 1);
                    n_state = mrps_pkg::S_MULA;
                end
            end
            mrps_pkg::S_MULA: begin
                n_x = w_rsp.sum;
                n_m = r_m << 1;
                n_q = r_q >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    // square of the sum goes next
                    n_y     = '0;
                    n_m     = mrps_pkg::t_alu_word'(i_stats.sum);
                    n_q     = i_stats.sum;
                    n_cnt   = mrps_pkg::t_step'(mrps_pkg::MUL_B_STEPS - 1);
                    n_state = mrps_pkg::S_MULB;
                end
            end
            mrps_pkg::S_MULB: begin
                n_y = w_rsp.sum[mrps_pkg::PROD_W-1:0];
                n_m = r_m << 1;
                n_q = r_q >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = mrps_pkg::S_SUB;
                end
            end
            mrps_pkg::S_SUB: begin
                n_rem  = '0;
                n_cnt  = mrps_pkg::t_step'(mrps_pkg::ROOT_STEPS - 1);
                if (w_rsp.no_borrow) begin
                    n_x     = {w_rsp.sum[mrps_pkg::PROD_W-1:0], 16'h0000};
                    n_root  = '0;
                    n_state = mrps_pkg::S_SQRT;
                end else begin
                    n_sd    = '0;
                    n_root  = w_mean_dvd;
                    n_cnt   = mrps_pkg::t_step'(mrps_pkg::DIV_STEPS - 1);
                    n_state = mrps_pkg::S_DMEAN;
                end
            end
            mrps_pkg::S_SQRT: begin
                n_x    = r_x << 2;
                n_root = w_quot;
                n_rem  = w_rsp.no_borrow ? w_rsp.sum[mrps_pkg::REM_W-1:0] : w_sq_sh;
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    // the root now becomes the dividend
                    n_rem   = '0;
                    n_cnt   = mrps_pkg::t_step'(mrps_pkg::DIV_STEPS - 1);
                    n_state = mrps_pkg::S_DSD;
                end
            end
            mrps_pkg::S_DSD: begin
                n_root = w_quot;
                n_rem  = mrps_pkg::t_rem'(w_rsp.no_borrow
                         ? w_rsp.sum[mrps_pkg::DIVREM_W-1:0] : w_div_sh);
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_sd    = w_quot[mrps_pkg::SD_W-1:0];
                    n_root  = w_mean_dvd;
                    n_rem   = '0;
                    n_cnt   = mrps_pkg::t_step'(mrps_pkg::DIV_STEPS - 1);
                    n_state = mrps_pkg::S_DMEAN;
                end
            end
            mrps_pkg::S_DMEAN: begin
                n_root = w_quot;
                n_rem  = mrps_pkg::t_rem'(w_rsp.no_borrow
                         ? w_rsp.sum[mrps_pkg::DIVREM_W-1:0] : w_div_sh);
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_mean  = w_quot[mrps_pkg::MEAN_W-1:0];
                    n_state = mrps_pkg::S_DONE;
                end
            end
            mrps_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = mrps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mrps_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrps_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_m    <= n_m;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_sd   <= n_sd;
        r_mean <= n_mean;
    end

    assign o_idle = (r_state == mrps_pkg::S_IDLE);
    assign o_done = (r_state == mrps_pkg::S_DONE) && i_out_free;
    assign o_mean = r_mean;
    assign o_sd   = r_sd;

`ifndef SYNTHESIS
    // n * sum of squares never falls below the squared sum
    a_var_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mrps_pkg::S_SUB) |-> w_rsp.no_borrow)
        else $error("variance numerator negative");

    a_load_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mrps_pkg::S_LOAD) |-> $past(r_state == mrps_pkg::S_IDLE && i_start))
        else $error("sequence started without a last pixel");

    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mrps_pkg::S_DONE && i_stats.count != '0) |->
        (r_mean >= {i_stats.min, 8'h00} && r_mean <= {i_stats.max, 8'h00}))
        else $error("mean outside min/max");

    a_sd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mrps_pkg::S_DONE && i_stats.count != '0) |->
        (r_sd <= {i_stats.max - i_stats.min, 7'h00}))
        else $error("deviation above half the range");
`endif

endmodule
`default_nettype wire

FILE: rtl/masked_roi_pixel_stats.sv
`timescale 1ns / 1ps
`default_nettype none
// Pixels are taken at one pixel per cycle while the sequencer is idle. A pixel with tlast
// closes the region; its result passes through the bit-serial products, square root and
// divisions on the single shared add/subtract unit (skipped for an empty region), and is
// held back while an older result still waits. No pixel is taken while the result is
// computed; pixels flow again once it sits in the output register. Reset (synchronous,
// active low) drops any result and clears the accumulators and sequencer state.
// ----------------------------------------------------------------------------
// masked_roi_pixel_stats: masked ROI minimum, maximum, mean and deviation
// Accumulates masked pixels of a region and, on its last pixel, emits count,
// minimum, maximum, mean and population standard deviation in fixed point
// with 8 fraction bits.
// ----------------------------------------------------------------------------
module masked_roi_pixel_stats (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [15:0]  s_axis_tdata,   // [15:0] pixel_value
    input  wire  [0:0]   s_axis_tuser,   // [0] in_roi
    input  wire          s_axis_tlast,   // last_pixel
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [103:0] m_axis_tdata,   // [23:0] mean_fixed, [39:24] min_value,
                                         // [55:40] max_value, [78:56] std_dev_fixed,
                                         // [99:79] pixel_count, [103:100] zero
    output logic [0:0]   m_axis_tuser    // [0] empty_res
);

    mrps_pkg::t_acc_stats w_stats;
    logic                 w_accept;
    logic                 w_idle;
    logic                 w_done;
    logic                 w_out_free;
    logic [mrps_pkg::MEAN_W-1:0] w_mean;
    logic [mrps_pkg::SD_W-1:0]   w_sd;

    logic         r_out_valid, n_out_valid;
    logic [103:0] r_out_data;
    logic         r_out_empty;

    // a pixel transaction completes only while the sequencer rests
    assign s_axis_tready = w_idle;
    assign w_accept      = s_axis_tvalid && w_idle;

    // the output register can take a new result when empty or being drained
    assign w_out_free = !r_out_valid || m_axis_tready;

    mrps_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_accept),
        .i_pix   (s_axis_tdata),
        .i_roi   (s_axis_tuser[0]),
        .i_clear (w_done),
        .o_stats (w_stats)
    );

    mrps_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && s_axis_tlast),
        .i_stats    (w_stats),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_done     (w_done),
        .o_mean     (w_mean),
        .o_sd       (w_sd)
    );

    // hold the result until the master-side transaction completes
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_done) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // capture the result together with the accumulator snapshot before it clears
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_data  <= {4'h0, w_stats.count, w_sd, w_stats.max, w_stats.min, w_mean};
            r_out_empty <= (w_stats.count == '0);
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_empty;

endmodule
`default_nettype wire
